// ===== rtl/core/dqb_pkg.sv =====
`timescale 1ns / 1ps

package dqb_pkg;

  localparam int CoordFracBits = 8;
  localparam int OffsetFrac    = 22;
  localparam int RoundShift    = OffsetFrac - CoordFracBits;
  localparam int LimitShift    = 2 * CoordFracBits;
  localparam int NzThreshold   = 16220;

  // unit vector pipeline: one quotient bit or one root bit per stage
  localparam int DivSteps  = 29;
  localparam int SqrtSteps = 16;

  localparam logic [1:0]  EffectLevelRst = 2'd0;
  localparam logic [31:0] FarLimitRst    = 32'd640000;
  localparam logic [31:0] NearLimitRst   = 32'd250000;
  localparam logic [15:0] MarkScaleRst   = 16'd1280;

  typedef enum logic [1:0] {
    CfgEffectLevel = 2'd0,
    CfgFarLimit    = 2'd1,
    CfgNearLimit   = 2'd2,
    CfgMarkScale   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [31:0] viewer_x;
    logic [31:0] viewer_y;
    logic [31:0] viewer_z;
  } dqb_in_t;

  typedef struct packed {
    logic [31:0] corner_x;
    logic [31:0] corner_y;
    logic [31:0] corner_z;
    logic        tex_u;
    logic        tex_v;
    logic [1:0]  corner_index;
    logic        last;
  } dqb_out_t;

  // hit point and a 16 bit vector carried alongside the unit vector pipeline
  typedef struct packed {
    logic [2:0][31:0] hit;
    logic [2:0][15:0] vec;
  } side_t;

endpackage

// ===== rtl/core/decal_quad_builder_unit.sv =====
`timescale 1ns / 1ps

// Decal quad builder.
// Input channel (in_valid_i / in_stall_o / in_item_i): one hit point, surface
// normal and viewer position per item. Output channel (out_valid_o /
// out_stall_i / out_item_o): four corner items per kept hit, in corner order,
// the fourth flagged last. Culled hits give no output at all.
// Config port: cfg_we_i writes cfg_data_i to the register chosen by cfg_idx_i
// (effect level, far limit, near limit, mark scale); write only while idle.
// Path: the two unit vector passes (29 divider stages and 16 root stages
// each) make up most of the pipeline. Corners leave one a cycle while
// out_stall_i is low; an item's four corners leave the single output
// register in turn, and the pipeline takes an item every cycle while that
// register is empty or its last corner is being taken.
// Reset: pipeline empties, registers return to their defaults.
// Stall: a stalled corner holds; the whole pipeline freezes once the output
// register cannot be freed, and in_stall_o rises until it can.
module decal_quad_builder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dqb_pkg::dqb_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dqb_pkg::dqb_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import dqb_pkg::*;

  logic [1:0]  effect_level_q;
  logic [31:0] far_limit_sq_q;
  logic [31:0] near_limit_sq_q;
  logic [15:0] mark_scale_q;

  logic adv;

  // stage 1: differences
  logic             s1_v_q;
  logic [2:0][32:0] s1_d_q;
  side_t            s1_side_q;
  // stage 2: squared differences
  logic             s2_v_q;
  logic [2:0][64:0] s2_sq_q;
  side_t            s2_side_q;
  // stage 3: cull and first cross product
  logic             s3_v_q;
  logic [2:0][31:0] s3_raw_q;
  side_t            s3_side_q;
  logic [66:0]      dist_sq;
  logic             keep;
  logic [2:0][31:0] raw1;
  side_t            side_in;

  logic             u1_v;
  logic [2:0][15:0] u1_vec;
  side_t            u1_side;
  logic             c_v_q;
  logic [2:0][31:0] c_raw_q, c_raw_d;
  side_t            c_side_q, c_side_d;
  logic             u2_v;
  logic [2:0][15:0] u2_vec;
  side_t            u2_side;

  // scaled offsets: a along (right + up), b along (right - up)
  logic             e_v_q;
  logic [2:0][33:0] e_a_q, e_b_q, e_a_d, e_b_d;
  logic [2:0][31:0] e_hit_q;
  logic             f_v_q;
  logic [2:0][33:0] f_a_q, f_b_q;
  logic [2:0][31:0] f_hit_q;

  logic             o_v_q;
  logic [1:0]       o_k_q;
  logic [2:0][33:0] o_a_q, o_b_q;
  logic [2:0][31:0] o_hit_q;
  logic [2:0][31:0] corner;

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // round to nearest, ties away from zero
  function automatic logic [33:0] rnd(logic [33:0] v);
    logic [33:0] m;
    m = v[33] ? -v : v;
    m = (m + (34'(1) << (RoundShift - 1))) >> RoundShift;
    return v[33] ? -m : m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_level_q  <= EffectLevelRst;
      far_limit_sq_q  <= FarLimitRst;
      near_limit_sq_q <= NearLimitRst;
      mark_scale_q    <= MarkScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEffectLevel: effect_level_q  <= cfg_data_i[1:0];
        CfgFarLimit:    far_limit_sq_q  <= cfg_data_i;
        CfgNearLimit:   near_limit_sq_q <= cfg_data_i;
        CfgMarkScale:   mark_scale_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign adv        = !o_v_q || (!out_stall_i && (o_k_q == 2'd3));
  assign in_stall_o = !adv;

  assign side_in.hit = {in_item_i.hit_z, in_item_i.hit_y, in_item_i.hit_x};
  assign side_in.vec = {in_item_i.normal_z, in_item_i.normal_y, in_item_i.normal_x};

  always_comb begin
    logic [15:0] nz;
    nz      = s2_side_q.vec[2];
    dist_sq = 67'(s2_sq_q[0]) + 67'(s2_sq_q[1]) + 67'(s2_sq_q[2]);
    keep = !((effect_level_q != 2'd0) && (dist_sq > (67'(far_limit_sq_q) << LimitShift)))
        && !((effect_level_q == 2'd2) && (dist_sq > (67'(near_limit_sq_q) << LimitShift)));
    // helper up is +y when the normal is nearly along z
    if ($signed(nz) > 16'(NzThreshold) || $signed(nz) < -16'(NzThreshold)) begin
      raw1[0] = ext16(nz);
      raw1[1] = '0;
      raw1[2] = -ext16(s2_side_q.vec[0]);
    end else begin
      raw1[0] = -ext16(s2_side_q.vec[1]);
      raw1[1] = ext16(s2_side_q.vec[0]);
      raw1[2] = '0;
    end
  end

  always_comb begin
    logic signed [31:0] r0, r1, r2, n0, n1, n2;
    r0 = ext16(u1_vec[0]);
    r1 = ext16(u1_vec[1]);
    r2 = ext16(u1_vec[2]);
    n0 = ext16(u1_side.vec[0]);
    n1 = ext16(u1_side.vec[1]);
    n2 = ext16(u1_side.vec[2]);
    c_raw_d[0]   = r1 * n2 - r2 * n1;
    c_raw_d[1]   = r2 * n0 - r0 * n2;
    c_raw_d[2]   = r0 * n1 - r1 * n0;
    c_side_d.hit = u1_side.hit;
    c_side_d.vec = u1_vec;
  end

  always_comb begin
    logic signed [33:0] r, u, sc;
    sc = 34'(mark_scale_q);
    for (int i = 0; i < 3; i++) begin
      r = 34'($signed(u2_side.vec[i]));
      u = 34'($signed(u2_vec[i]));
      e_a_d[i] = (r + u) * sc;
      e_b_d[i] = (r - u) * sc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      c_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
      f_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && keep;
      c_v_q  <= u1_v;
      e_v_q  <= u2_v;
      f_v_q  <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] m;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_q[i]  <= {side_in.hit[i][31], side_in.hit[i]}
                    - {in_item_i[(2-i)*32 +: 32][31], in_item_i[(2-i)*32 +: 32]};
        m           = s1_d_q[i][32] ? -s1_d_q[i] : s1_d_q[i];
        s2_sq_q[i] <= 65'(m) * 65'(m);
        f_a_q[i]   <= rnd(e_a_q[i]);
        f_b_q[i]   <= rnd(e_b_q[i]);
      end
      s1_side_q <= side_in;
      s2_side_q <= s1_side_q;
      s3_raw_q  <= raw1;
      s3_side_q <= s2_side_q;
      c_raw_q   <= c_raw_d;
      c_side_q  <= c_side_d;
      e_a_q     <= e_a_d;
      e_b_q     <= e_b_d;
      e_hit_q   <= u2_side.hit;
      f_hit_q   <= e_hit_q;
      o_a_q     <= f_a_q;
      o_b_q     <= f_b_q;
      o_hit_q   <= f_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      o_k_q <= 2'd0;
    end else if (adv) begin
      o_v_q <= f_v_q;
      o_k_q <= 2'd0;
    end else if (!out_stall_i) begin
      o_k_q <= o_k_q + 2'd1;
    end
  end

  dqb_unitize u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_v_q),
    .comp_i  (s3_raw_q),
    .side_i  (s3_side_q),
    .valid_o (u1_v),
    .unit_o  (u1_vec),
    .side_o  (u1_side)
  );

  dqb_unitize u_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_v_q),
    .comp_i  (c_raw_q),
    .side_i  (c_side_q),
    .valid_o (u2_v),
    .unit_o  (u2_vec),
    .side_o  (u2_side)
  );

  // corner offsets in order: -a, -b, a, b
  always_comb begin
    logic [33:0] off;
    logic [34:0] sum;
    for (int i = 0; i < 3; i++) begin
      case (o_k_q)
        2'd0:    off = -o_a_q[i];
        2'd1:    off = -o_b_q[i];
        2'd2:    off = o_a_q[i];
        default: off = o_b_q[i];
      endcase
      sum = {{3{o_hit_q[i][31]}}, o_hit_q[i]} + {off[33], off};
      if ($signed(sum) > $signed(35'h0_7FFF_FFFF)) begin
        corner[i] = 32'h7FFF_FFFF;
      end else if ($signed(sum) < $signed({3'b111, 32'h8000_0000})) begin
        corner[i] = 32'h8000_0000;
      end else begin
        corner[i] = sum[31:0];
      end
    end
  end

  assign out_valid_o             = o_v_q;
  assign out_item_o.corner_x     = corner[0];
  assign out_item_o.corner_y     = corner[1];
  assign out_item_o.corner_z     = corner[2];
  assign out_item_o.tex_u        = (o_k_q == 2'd0) || (o_k_q == 2'd1);
  assign out_item_o.tex_v        = (o_k_q == 2'd1) || (o_k_q == 2'd2);
  assign out_item_o.corner_index = o_k_q;
  assign out_item_o.last         = (o_k_q == 2'd3);

endmodule

// ===== rtl/core/dqb_unitize.sv =====
`timescale 1ns / 1ps

module dqb_unitize (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][31:0]    comp_i,
  input  dqb_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [2:0][15:0]    unit_o,
  output dqb_pkg::side_t      side_o
);
  import dqb_pkg::*;

  // stage a: squares
  logic                  va_q;
  logic [2:0]            neg_a_q, neg_a_d;
  logic [2:0][61:0]      sq_a_q, sq_a_d;
  side_t                 side_a_q;

  // stage b: squared length
  logic                  vb_q;
  logic [2:0]            neg_b_q;
  logic [2:0][61:0]      sq_b_q;
  logic [61:0]           len_b_q;
  side_t                 side_b_q;

  // restoring divider, one quotient bit per stage
  logic                  dv_v_q   [DivSteps];
  logic [2:0]            dv_neg_q [DivSteps];
  logic [61:0]           dv_len_q [DivSteps];
  side_t                 dv_side_q[DivSteps];
  logic [62:0]           dv_rem_q [DivSteps][3];
  logic [62:0]           dv_rem_d [DivSteps][3];
  logic [DivSteps-1:0]   dv_quo_q [DivSteps][3];
  logic [DivSteps-1:0]   dv_quo_d [DivSteps][3];

  // integer square root, one root bit per stage
  logic                  sr_v_q   [SqrtSteps];
  logic                  sr_zero_q[SqrtSteps];
  logic [2:0]            sr_neg_q [SqrtSteps];
  side_t                 sr_side_q[SqrtSteps];
  logic [DivSteps-1:0]   sr_x_q   [SqrtSteps][3];
  logic [15:0]           sr_r_q   [SqrtSteps][3];
  logic [15:0]           sr_r_d   [SqrtSteps][3];
  logic [32:0]           sr_rsq_q [SqrtSteps][3];
  logic [32:0]           sr_rsq_d [SqrtSteps][3];

  always_comb begin
    logic [31:0] c;
    logic [30:0] m;
    for (int i = 0; i < 3; i++) begin
      c = comp_i[i];
      m = c[31] ? 31'(-c) : c[30:0];
      neg_a_d[i] = c[31];
      sq_a_d[i]  = 62'(m) * 62'(m);
    end
  end

  always_comb begin
    logic [62:0] t;
    for (int i = 0; i < 3; i++) begin
      t = {1'b0, sq_b_q[i]};
      if (t >= {1'b0, len_b_q}) begin
        dv_rem_d[0][i] = t - {1'b0, len_b_q};
        dv_quo_d[0][i] = DivSteps'(1);
      end else begin
        dv_rem_d[0][i] = t;
        dv_quo_d[0][i] = '0;
      end
    end
    for (int s = 1; s < DivSteps; s++) begin
      for (int i = 0; i < 3; i++) begin
        t = {dv_rem_q[s-1][i][61:0], 1'b0};
        if (t >= {1'b0, dv_len_q[s-1]}) begin
          dv_rem_d[s][i] = t - {1'b0, dv_len_q[s-1]};
          dv_quo_d[s][i] = {dv_quo_q[s-1][i][DivSteps-2:0], 1'b1};
        end else begin
          dv_rem_d[s][i] = t;
          dv_quo_d[s][i] = {dv_quo_q[s-1][i][DivSteps-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [15:0]         r;
    logic [32:0]         rsq;
    logic [32:0]         t2;
    logic [DivSteps-1:0] x;
    for (int s = 0; s < SqrtSteps; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          r   = '0;
          rsq = '0;
          x   = dv_quo_q[DivSteps-1][i];
        end else begin
          r   = sr_r_q[s-1][i];
          rsq = sr_rsq_q[s-1][i];
          x   = sr_x_q[s-1][i];
        end
        // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
        t2 = rsq + (33'(r) << (SqrtSteps - s)) + (33'(1) << (2 * (SqrtSteps - 1 - s)));
        if (t2 <= 33'(x)) begin
          sr_r_d[s][i]   = r | (16'(1) << (SqrtSteps - 1 - s));
          sr_rsq_d[s][i] = t2;
        end else begin
          sr_r_d[s][i]   = r;
          sr_rsq_d[s][i] = rsq;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      for (int s = 0; s < DivSteps; s++) dv_v_q[s] <= 1'b0;
      for (int s = 0; s < SqrtSteps; s++) sr_v_q[s] <= 1'b0;
    end else if (en_i) begin
      va_q      <= valid_i;
      vb_q      <= va_q;
      dv_v_q[0] <= vb_q;
      for (int s = 1; s < DivSteps; s++) dv_v_q[s] <= dv_v_q[s-1];
      sr_v_q[0] <= dv_v_q[DivSteps-1];
      for (int s = 1; s < SqrtSteps; s++) sr_v_q[s] <= sr_v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= neg_a_d;
      sq_a_q   <= sq_a_d;
      side_a_q <= side_i;
      neg_b_q  <= neg_a_q;
      sq_b_q   <= sq_a_q;
      len_b_q  <= sq_a_q[0] + sq_a_q[1] + sq_a_q[2];
      side_b_q <= side_a_q;
      for (int s = 0; s < DivSteps; s++) begin
        dv_neg_q[s]  <= (s == 0) ? neg_b_q  : dv_neg_q[(s == 0) ? 0 : s-1];
        dv_len_q[s]  <= (s == 0) ? len_b_q  : dv_len_q[(s == 0) ? 0 : s-1];
        dv_side_q[s] <= (s == 0) ? side_b_q : dv_side_q[(s == 0) ? 0 : s-1];
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[s][i] <= dv_rem_d[s][i];
          dv_quo_q[s][i] <= dv_quo_d[s][i];
        end
      end
      for (int s = 0; s < SqrtSteps; s++) begin
        if (s == 0) begin
          sr_zero_q[s] <= (dv_len_q[DivSteps-1] == '0);
          sr_neg_q[s]  <= dv_neg_q[DivSteps-1];
          sr_side_q[s] <= dv_side_q[DivSteps-1];
          for (int i = 0; i < 3; i++) sr_x_q[s][i] <= dv_quo_q[DivSteps-1][i];
        end else begin
          sr_zero_q[s] <= sr_zero_q[s-1];
          sr_neg_q[s]  <= sr_neg_q[s-1];
          sr_side_q[s] <= sr_side_q[s-1];
          for (int i = 0; i < 3; i++) sr_x_q[s][i] <= sr_x_q[s-1][i];
        end
        for (int i = 0; i < 3; i++) begin
          sr_r_q[s][i]   <= sr_r_d[s][i];
          sr_rsq_q[s][i] <= sr_rsq_d[s][i];
        end
      end
    end
  end

  // zero length vector gives the zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sr_zero_q[SqrtSteps-1]) begin
        unit_o[i] = '0;
      end else if (sr_neg_q[SqrtSteps-1][i]) begin
        unit_o[i] = -sr_r_q[SqrtSteps-1][i];
      end else begin
        unit_o[i] = sr_r_q[SqrtSteps-1][i];
      end
    end
  end

  assign valid_o = sr_v_q[SqrtSteps-1];
  assign side_o  = sr_side_q[SqrtSteps-1];

endmodule

// ===== rtl/core/dqb_checker.sv =====
`timescale 1ns / 1ps

module dqb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dqb_pkg::dqb_out_t out_item_o
);
  import dqb_pkg::*;

  // a stalled corner item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // corners of one quad leave back to back, in order
  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last
    |=> out_valid_o && (out_item_o.corner_index == $past(out_item_o.corner_index) + 2'd1))
    else $error("corner sequence broken");

  // a quad opens with corner 0 after its predecessor closed
  a_quad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.last
    |=> !out_valid_o || (out_item_o.corner_index == 2'd0))
    else $error("quad does not start at corner 0");

  // texture coordinates follow the corner
  a_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.tex_u == !out_item_o.corner_index[1])
                 && (out_item_o.tex_v == (out_item_o.corner_index[0] ^ out_item_o.corner_index[1])))
    else $error("texture coordinate mismatch");

  // intake only stalls while a corner is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o)
    else $error("intake stalled with no output pending");

endmodule

bind decal_quad_builder_unit dqb_checker u_dqb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
